// ----- hdl/fl32_pkg.sv -----
// Fletcher-32 shared package: the word command type, the sum start value,
// the queue sizing constants and the end-around-carry adder. No dependencies.
package fl32_pkg;

  localparam logic [15:0] SumInit = 16'hffff;

  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);

  // One assembled 16-bit word on its way to the summing stage.
  typedef struct packed {
    logic [15:0] word;
    logic        last;
  } word_cmd_t;

  // 16-bit add with end-around carry. For a in 1..65535 the result never
  // wraps to zero, so the zero value stays represented as 65535.
  function automatic logic [15:0] eac_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    begin
      s = {1'b0, a} + {1'b0, b};
      eac_add = s[15:0] + {15'd0, s[16]};
    end
  endfunction

endpackage

// ----- hdl/fl32_byte_if.sv -----
// Byte channel of the Fletcher-32 block: valid/ready with one message byte
// and its end-of-message mark. No dependencies.
interface fl32_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- hdl/fl32_sum_if.sv -----
// Checksum channel of the Fletcher-32 block: valid/ready with one 32-bit
// checksum per message. No dependencies.
interface fl32_sum_if;
  logic        valid;
  logic        ready;
  logic [31:0] checksum;

  modport source (output valid, output checksum, input ready);
  modport sink   (input valid, input checksum, output ready);
endinterface

// ----- hdl/fletcher32_byte_checksum.sv -----
// Fletcher-32 byte-stream checksum, top level. Instantiates fl32_front,
// fl32_queue and fl32_back; uses fl32_pkg and the two channel interfaces.
//
// Takes one message byte per clock with no gaps, as long as the queue has
// room; bytes pair into big-endian words, an odd final byte is padded with
// a zero low byte. The checksum (high sum in bits 31..16, low sum in bits
// 15..0) is registered after the final byte passes through the four-entry
// word queue and then the summing stage, whose two chained 16-bit
// end-around-carry adds set the clock. The sums restart at 65535 for the
// next message at once. A stalled checksum output backs up the queue and
// then the byte input.
module fletcher32_byte_checksum (
  input  logic       clk,
  input  logic       rst,
  fl32_byte_if.sink  byte_chan,
  fl32_sum_if.source sum_chan
);

  logic                push_valid;
  logic                push_ready;
  fl32_pkg::word_cmd_t push_cmd;
  logic                pop_valid;
  logic                pop_ready;
  fl32_pkg::word_cmd_t pop_cmd;

  fl32_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_chan  (byte_chan),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready)
  );

  fl32_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd),
    .pop_ready  (pop_ready)
  );

  fl32_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_cmd   (pop_cmd),
    .pop_ready (pop_ready),
    .sum_chan  (sum_chan)
  );

endmodule

// ----- hdl/fl32_front.sv -----
// Front end: pairs incoming bytes into big-endian words and pushes a word
// command on every second byte or on the final byte. Uses fl32_pkg.
module fl32_front (
  input  logic                 clk,
  input  logic                 rst,
  fl32_byte_if.sink            byte_chan,
  output logic                 push_valid,
  output fl32_pkg::word_cmd_t  push_cmd,
  input  logic                 push_ready
);

  logic [7:0] held_byte;
  logic       byte_pending;
  logic       take;

  // Stall the byte side whenever the queue is full, even for a byte that
  // would only be held; keeps the ready path free of the payload.
  assign byte_chan.ready = push_ready;
  assign take            = byte_chan.valid && push_ready;

  assign push_valid    = byte_chan.valid && (byte_pending || byte_chan.last_byte);
  assign push_cmd.last = byte_chan.last_byte;
  assign push_cmd.word = byte_pending ? {held_byte, byte_chan.data_byte}
                                      : {byte_chan.data_byte, 8'h00};

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pending <= 1'b0;
    end else if (take) begin
      // hold a leading byte; drop it once its word goes out
      byte_pending <= !byte_pending && !byte_chan.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (take && !byte_pending) begin
      held_byte <= byte_chan.data_byte;
    end
  end

endmodule

// ----- hdl/fl32_queue.sv -----
// Short word queue between the front end and the summing stage.
// Uses fl32_pkg for the command type and depth.
module fl32_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push_valid,
  input  fl32_pkg::word_cmd_t  push_cmd,
  output logic                 push_ready,
  output logic                 pop_valid,
  output fl32_pkg::word_cmd_t  pop_cmd,
  input  logic                 pop_ready
);

  fl32_pkg::word_cmd_t            slots [fl32_pkg::QueueDepth];
  logic [fl32_pkg::QueuePtrW-1:0] wr_ptr;
  logic [fl32_pkg::QueuePtrW-1:0] rd_ptr;
  logic [fl32_pkg::QueuePtrW:0]   count;
  logic                           push;
  logic                           pop;

  assign push_ready = count != (fl32_pkg::QueuePtrW + 1)'(fl32_pkg::QueueDepth);
  assign pop_valid  = count != '0;
  assign pop_cmd    = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ----- hdl/fl32_back.sv -----
// Summing stage: folds each word into the two end-around-carry sums and
// registers the checksum at the end of a message. Uses fl32_pkg.
module fl32_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pop_valid,
  input  fl32_pkg::word_cmd_t  pop_cmd,
  output logic                 pop_ready,
  fl32_sum_if.source           sum_chan
);

  logic [15:0] low_sum;
  logic [15:0] high_sum;
  logic [15:0] low_next;
  logic [15:0] high_next;
  logic        out_valid;
  logic [31:0] checksum;
  logic        pop;

  assign pop_ready = !out_valid || sum_chan.ready;
  assign pop       = pop_valid && pop_ready;

  assign low_next  = fl32_pkg::eac_add(low_sum, pop_cmd.word);
  assign high_next = fl32_pkg::eac_add(high_sum, low_next);

  assign sum_chan.valid    = out_valid;
  assign sum_chan.checksum = checksum;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_sum   <= fl32_pkg::SumInit;
      high_sum  <= fl32_pkg::SumInit;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        // restart the sums after the final word
        low_sum  <= pop_cmd.last ? fl32_pkg::SumInit : low_next;
        high_sum <= pop_cmd.last ? fl32_pkg::SumInit : high_next;
      end
      if (pop && pop_cmd.last) begin
        out_valid <= 1'b1;
      end else if (sum_chan.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && pop_cmd.last) begin
      checksum <= {high_next, low_next};
    end
  end

endmodule
